/* rtl/sle_pkg.sv */
// shared types and codes for the sequence list engine
package sle_pkg;

  typedef enum logic [2:0] {
    MODE_GET    = 3'd0,
    MODE_LOCATE = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ERROR     = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CONFLICT  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GET_WAIT,
    S_LOCATE,
    S_INSERT,
    S_DELETE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_PTR,
    RD_PTR_M1
  } rd_sel_t;

  typedef enum logic [1:0] {
    PTR_ZERO,
    PTR_COUNT,
    PTR_POS
  } ptr_sel_t;

  typedef struct packed {
    logic     load;
    logic     ptr_ld;
    ptr_sel_t ptr_sel;
    logic     ptr_inc;
    logic     ptr_dec;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     elem_rd;
    logic     scan_rd;
    logic     shift_rd;
    logic     wr_val;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     cnt_clr;
    logic     set_status;
    status_t  status_code;
    logic     out_load;
  } sle_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  pos_get_ok;
    logic  pos_ins_ok;
    logic  full;
    logic  append;
    logic  count_zero;
    logic  ptr_at_count;
    logic  ptr_at_pos;
    logic  pend;
    logic  hit;
    logic  conflict;
    logic  out_busy;
  } sle_flags_t;

endpackage

/* rtl/sle_ctrl.sv */
// controller state machine sequencing each list operation
module sle_ctrl
  import sle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  sle_flags_t flags,
  output sle_cmd_t   cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_status = 1'b1;
        unique case (flags.mode)
          MODE_GET: begin
            if (!flags.pos_get_ok) begin
              cmd.status_code = ST_ERROR;
              state_next      = S_DONE;
            end else begin
              cmd.rd_en       = 1'b1;
              cmd.rd_sel      = RD_POS;
              cmd.elem_rd     = 1'b1;
              cmd.status_code = ST_OK;
              state_next      = S_GET_WAIT;
            end
          end
          MODE_LOCATE: begin
            cmd.status_code = ST_NOT_FOUND;
            if (flags.count_zero) begin
              state_next = S_DONE;
            end else begin
              cmd.ptr_ld  = 1'b1;
              cmd.ptr_sel = PTR_ZERO;
              state_next  = S_LOCATE;
            end
          end
          MODE_INSERT: begin
            if (!flags.pos_ins_ok) begin
              cmd.status_code = ST_ERROR;
              state_next      = S_DONE;
            end else if (flags.full) begin
              cmd.status_code = ST_OVERFLOW;
              state_next      = S_DONE;
            end else if (flags.append) begin
              cmd.wr_val      = 1'b1;
              cmd.cnt_inc     = 1'b1;
              cmd.status_code = ST_OK;
              state_next      = S_DONE;
            end else begin
              cmd.ptr_ld      = 1'b1;
              cmd.ptr_sel     = PTR_COUNT;
              cmd.status_code = ST_OK;
              state_next      = S_INSERT;
            end
          end
          MODE_DELETE: begin
            if (!flags.pos_get_ok) begin
              cmd.status_code = ST_ERROR;
              state_next      = S_DONE;
            end else begin
              cmd.rd_en       = 1'b1;
              cmd.rd_sel      = RD_POS;
              cmd.elem_rd     = 1'b1;
              cmd.ptr_ld      = 1'b1;
              cmd.ptr_sel     = PTR_POS;
              cmd.status_code = ST_OK;
              state_next      = S_DELETE;
            end
          end
          MODE_CLEAR: begin
            cmd.cnt_clr     = 1'b1;
            cmd.status_code = ST_OK;
            state_next      = S_DONE;
          end
          default: begin
            cmd.status_code = ST_ERROR;
            state_next      = S_DONE;
          end
        endcase
      end
      S_GET_WAIT: begin
        state_next = S_DONE;
      end
      S_LOCATE: begin
        if (!flags.ptr_at_count) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_PTR;
          cmd.scan_rd = 1'b1;
          cmd.ptr_inc = 1'b1;
        end else if (!flags.pend) begin
          cmd.set_status = 1'b1;
          if (flags.conflict) begin
            cmd.status_code = ST_CONFLICT;
          end else if (flags.hit) begin
            cmd.status_code = ST_OK;
          end else begin
            cmd.status_code = ST_NOT_FOUND;
          end
          state_next = S_DONE;
        end
      end
      S_INSERT: begin
        if (!flags.ptr_at_pos) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_PTR_M1;
          cmd.shift_rd = 1'b1;
          cmd.ptr_dec  = 1'b1;
        end else if (!flags.pend) begin
          cmd.wr_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DELETE: begin
        if (!flags.ptr_at_count) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_PTR;
          cmd.shift_rd = 1'b1;
          cmd.ptr_inc  = 1'b1;
        end else if (!flags.pend) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DONE: begin
        if (!flags.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sle_datapath.sv */
// list store, pointers, length, capacity register and result register
module sle_datapath
  import sle_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [6:0]         cfg_write_data,
  input  logic [2:0]         mode,
  input  logic [6:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [6:0]         found_position,
  output logic signed [31:0] element_out,
  output logic [6:0]         list_length,
  output logic               is_empty,
  input  sle_cmd_t           cmd,
  output sle_flags_t         flags
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > 7) ? CW : 7) + 1;

  logic [ELEM_WIDTH-1:0]        mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] rdata;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                wr_addr;

  logic [2:0]            mode_r;
  logic [6:0]            pos_r;
  logic [ELEM_WIDTH-1:0] val_r;
  logic [CW-1:0]         count;
  logic [CW-1:0]         ptr;
  logic [6:0]            capacity;
  logic                  cmp_pend;
  logic                  wr_pend;
  logic                  elem_pend;
  logic [CW-1:0]         found;
  logic                  conflict;
  logic signed [31:0]    elem;
  status_t               status_r;

  logic [CW-1:0] pos_m1;
  logic          match;

  assign pos_m1 = CW'(XW'(pos_r) - XW'(1));
  assign match  = (rdata == val_r);

  // operation fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      pos_r  <= position;
      val_r  <= ELEM_WIDTH'(value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 7'd64;
    end else if (cfg_write_en) begin
      capacity <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_ld) begin
      unique case (cmd.ptr_sel)
        PTR_ZERO:  ptr <= '0;
        PTR_COUNT: ptr <= count;
        PTR_POS:   ptr <= CW'(pos_r);
        default:   ptr <= '0;
      endcase
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + CW'(1);
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - CW'(1);
    end
  end

  // store read and write ports
  always_comb begin
    unique case (cmd.rd_sel)
      RD_POS:    rd_addr = AW'(pos_m1);
      RD_PTR:    rd_addr = AW'(ptr);
      RD_PTR_M1: rd_addr = AW'(ptr - CW'(1));
      default:   rd_addr = AW'(ptr);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_val) begin
      mem[AW'(pos_m1)] <= val_r;
    end else if (wr_pend) begin
      mem[wr_addr] <= rdata;
    end
  end

  // shift destination sits one above the read on insert, one below on delete
  always_ff @(posedge clk) begin
    if (cmd.shift_rd) begin
      if (mode_r == MODE_INSERT) begin
        wr_addr <= AW'(ptr);
      end else begin
        wr_addr <= AW'(ptr - CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend  <= 1'b0;
      wr_pend   <= 1'b0;
      elem_pend <= 1'b0;
    end else begin
      cmp_pend  <= cmd.scan_rd;
      wr_pend   <= cmd.shift_rd;
      elem_pend <= cmd.elem_rd;
    end
  end

  // per-operation results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found    <= '0;
      conflict <= 1'b0;
      elem     <= '0;
    end else begin
      if (cmp_pend && match) begin
        if (found == '0) begin
          found <= ptr;
        end else begin
          conflict <= 1'b1;
        end
      end
      if (elem_pend) begin
        elem <= 32'(rdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= status_r;
      found_position <= 7'(found);
      element_out    <= elem;
      list_length    <= 7'(count);
      is_empty       <= (count == '0);
    end
  end

  always_comb begin
    flags.mode         = mode_t'(mode_r);
    flags.pos_get_ok   = (pos_r != 7'd0) && (XW'(pos_r) <= XW'(count));
    flags.pos_ins_ok   = (pos_r != 7'd0) && (XW'(pos_r) <= XW'(count) + XW'(1));
    flags.full         = (XW'(count) >= XW'(capacity)) || (count == CW'(DEPTH));
    flags.append       = (pos_m1 == count);
    flags.count_zero   = (count == '0);
    flags.ptr_at_count = (ptr == count);
    flags.ptr_at_pos   = (ptr == pos_m1);
    flags.pend         = cmp_pend || wr_pend;
    flags.hit          = (found != '0);
    flags.conflict     = conflict;
    flags.out_busy     = out_valid && out_stall;
  end

endmodule

/* rtl/sequence_list_engine.sv */
// sequence list engine: array-based ordered list, top level
// one operation at a time; the next transfer is taken once the result is registered
// locate reads every entry, insert shifts up the entries from the position on
// (none when appending), delete shifts down those above the position;
// one entry read per cycle
// synchronous reset empties the list and sets the capacity to 64; no clearing pass
module sequence_list_engine
  import sle_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [6:0]         cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic [6:0]         position,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [6:0]         found_position,
  output logic signed [31:0] element_out,
  output logic [6:0]         list_length,
  output logic               is_empty
);

  sle_cmd_t   cmd;
  sle_flags_t flags;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .cmd      (cmd)
  );

  sle_datapath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .mode           (mode),
    .position       (position),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_position (found_position),
    .element_out    (element_out),
    .list_length    (list_length),
    .is_empty       (is_empty),
    .cmd            (cmd),
    .flags          (flags)
  );

endmodule

/* tb/sequence_list_engine_test.sv */
// testbench for the sequence list engine: directed and random list operations, self-checking
module sequence_list_engine_test
  import sle_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  typedef struct {
    status_t     status;
    logic [6:0]  found;
    logic [31:0] elem;
    logic [6:0]  len;
    logic        empty;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic [6:0]         cfg_write_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         mode = '0;
  logic [6:0]         position = '0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic [6:0]         found_position;
  logic signed [31:0] element_out;
  logic [6:0]         list_length;
  logic               is_empty;

  logic [31:0]  mirror_list [LIST_DEPTH];
  int           mirror_len = 0;
  int           mirror_cap = 64;
  list_result_t expected_results [$];
  int           failures = 0;
  int           quiet_cycles = 0;
  bit           idle_in = 1'b1;
  bit           idle_out = 1'b1;
  bit           hold_request = 1'b0;

  logic [31:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A};

  sequence_list_engine dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .position      (position),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .found_position(found_position),
    .element_out   (element_out),
    .list_length   (list_length),
    .is_empty      (is_empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic list_result_t apply_list_op(logic [2:0] op, logic [6:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    int cap;
    int j;
    r.status = ST_ERROR;
    r.found = '0;
    r.elem = '0;
    cap = (mirror_cap < LIST_DEPTH) ? mirror_cap : LIST_DEPTH;
    unique case (op)
      MODE_GET: begin
        if (pos >= 1 && pos <= mirror_len) begin
          r.elem = mirror_list[pos - 1];
          r.status = ST_OK;
        end
      end
      MODE_LOCATE: begin
        r.status = ST_NOT_FOUND;
        for (j = 0; j < mirror_len; j++) begin
          if (mirror_list[j] == val) begin
            if (r.found == 0) begin
              r.found = 7'(j + 1);
              r.status = ST_OK;
            end else begin
              r.status = ST_CONFLICT;
              break;
            end
          end
        end
      end
      MODE_INSERT: begin
        if (pos < 1 || pos > mirror_len + 1) begin
          r.status = ST_ERROR;
        end else if (mirror_len >= cap) begin
          r.status = ST_OVERFLOW;
        end else begin
          for (j = mirror_len; j >= pos; j--) mirror_list[j] = mirror_list[j - 1];
          mirror_list[pos - 1] = val;
          mirror_len++;
          r.status = ST_OK;
        end
      end
      MODE_DELETE: begin
        if (pos >= 1 && pos <= mirror_len) begin
          r.elem = mirror_list[pos - 1];
          for (j = pos; j < mirror_len; j++) mirror_list[j - 1] = mirror_list[j];
          mirror_len--;
          r.status = ST_OK;
        end
      end
      MODE_CLEAR: begin
        foreach (mirror_list[k]) mirror_list[k] = '0;
        mirror_len = 0;
        r.status = ST_OK;
      end
      default: r.status = ST_ERROR;
    endcase
    r.len = 7'(mirror_len);
    r.empty = (mirror_len == 0);
    return r;
  endfunction

  task automatic send_op(logic [2:0] op, logic [6:0] pos, logic [31:0] val);
    int unsigned gap;
    gap = idle_in ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= op;
    position <= pos;
    value <= val;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_list_op(op, pos, val));
  endtask

  task automatic set_capacity(logic [6:0] cap);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= cap;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    mirror_cap = cap;
  endtask

  // mostly in-range positions and repeated values so that locate finds hits and conflicts
  task automatic send_random_op(int unsigned insert_weight);
    logic [2:0]  op;
    logic [6:0]  pos;
    logic [31:0] val;
    int unsigned pick;
    int          top;
    if ($urandom_range(0, 99) < insert_weight) begin
      op = MODE_INSERT;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 33) op = MODE_DELETE;
      else if (pick < 60) op = MODE_GET;
      else if (pick < 92) op = MODE_LOCATE;
      else if (pick < 95 && insert_weight < 50) op = MODE_CLEAR;
      else if (pick < 95) op = MODE_GET;
      else op = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    end
    top = (op == MODE_INSERT) ? mirror_len + 1 : mirror_len;
    if ($urandom_range(0, 9) < 9 && top >= 1) pos = 7'($urandom_range(1, top));
    else pos = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 1)) val = value_pool[$urandom_range(0, 7)];
    else val = $urandom();
    send_op(op, pos, val);
  endtask

  task automatic test_directed_ops();
    logic [2:0] m;
    set_capacity(7'd64);
    send_op(MODE_LOCATE, 7'd0, 32'h0000_0000);
    send_op(MODE_GET, 7'd1, 32'h0);
    send_op(MODE_DELETE, 7'd0, 32'h0);
    send_op(MODE_INSERT, 7'd2, 32'h1234_5678);
    send_op(MODE_INSERT, 7'd1, 32'h8000_0000);
    send_op(MODE_INSERT, 7'd2, 32'h7FFF_FFFF);
    send_op(MODE_INSERT, 7'd1, 32'hFFFF_FFFF);
    send_op(MODE_INSERT, 7'd127, 32'h0);
    send_op(MODE_GET, 7'd1, 32'h0);
    send_op(MODE_GET, 7'd3, 32'h0);
    send_op(MODE_GET, 7'd0, 32'h0);
    send_op(MODE_LOCATE, 7'd0, 32'h7FFF_FFFF);
    send_op(MODE_INSERT, 7'd4, 32'h8000_0000);
    send_op(MODE_LOCATE, 7'd0, 32'h8000_0000);
    send_op(MODE_LOCATE, 7'd127, 32'h0000_0000);
    send_op(MODE_DELETE, 7'd1, 32'h0);
    send_op(MODE_DELETE, 7'd3, 32'h0);
    for (m = MODE_UNUSED_LO; m != 3'(MODE_UNUSED_HI + 1); m++) send_op(m, 7'd1, 32'h0);
    send_op(MODE_CLEAR, 7'd0, 32'h0);
    send_op(MODE_GET, 7'd1, 32'h0);
  endtask

  task automatic test_capacity_limits();
    set_capacity(7'd1);
    send_op(MODE_INSERT, 7'd1, 32'h0000_0001);
    send_op(MODE_INSERT, 7'd2, 32'h0000_0002);
    send_op(MODE_INSERT, 7'd5, 32'h0000_0003);
    set_capacity(7'd0);
    send_op(MODE_INSERT, 7'd1, 32'h0000_0004);
    send_op(MODE_DELETE, 7'd1, 32'h0);
    send_op(MODE_INSERT, 7'd1, 32'h0000_0005);
    set_capacity(7'd127);
    repeat (3) send_op(MODE_INSERT, 7'd1, $urandom());
    set_capacity(7'd2);
    send_op(MODE_INSERT, 7'd1, 32'h0000_0006);
    send_op(MODE_GET, 7'd3, 32'h0);
  endtask

  // insert-heavy so the list runs up against the full depth
  task automatic test_random_fill();
    set_capacity(7'd64);
    repeat (150) send_random_op(70);
  endtask

  task automatic test_random_mixed();
    repeat (3) begin
      set_capacity(7'($urandom_range(1, 63)));
      repeat (50) send_random_op(45);
    end
  endtask

  task automatic test_backpressure();
    idle_in = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_random_op(50);
    idle_in = 1'b1;
  endtask

  task automatic test_random_unpaced();
    set_capacity(7'd127);
    idle_in = 1'b0;
    idle_out = 1'b0;
    repeat (100) send_random_op(45);
    idle_in = 1'b1;
    idle_out = 1'b1;
  endtask

  initial begin : result_sink
    int unsigned wait_cycles;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles = LONG_HOLD;
      end else begin
        wait_cycles = idle_out ? $urandom_range(0, 15) : 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status);
          failures++;
        end
        if (found_position !== want.found) begin
          $error("found_position expected %0d actual %0d", want.found, found_position);
          failures++;
        end
        if (element_out !== want.elem) begin
          $error("element_out expected %h actual %h", want.elem, element_out);
          failures++;
        end
        if (list_length !== want.len) begin
          $error("list_length expected %0d actual %0d", want.len, list_length);
          failures++;
        end
        if (is_empty !== want.empty) begin
          $error("is_empty expected %0d actual %0d", want.empty, is_empty);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        !(in_valid || expected_results.size() != 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (mirror_list[k]) mirror_list[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_capacity_limits();
    test_random_fill();
    test_random_mixed();
    test_backpressure();
    test_random_unpaced();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sle_pkg.sv
rtl/sle_ctrl.sv
rtl/sle_datapath.sv
rtl/sequence_list_engine.sv
tb/sequence_list_engine_test.sv
